>>> src/bsme_pkg.sv
// Shared constants, codes and control types for the byte stack machine executor.
// No dependencies; bsme_ctrl, bsme_dp and the core refer to it by scoped names, the bench imports it.
package bsme_pkg;

  // stack sizing
  localparam int STACK_DEPTH    = 256;
  localparam int SP_W           = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W         = $clog2(STACK_DEPTH);
  localparam int DEPTH_OUT_W    = 9;

  // variable store: data array first, letter variables after it
  localparam int VARIABLE_COUNT = 26;
  localparam int ARRAY_SIZE     = 128;
  localparam int VAR_DEPTH      = ARRAY_SIZE + VARIABLE_COUNT;
  localparam int VAR_AW         = $clog2(VAR_DEPTH);

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUE_VALUE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALSE_VALUE = 1'd1;

  // operation codes
  localparam logic [4:0] OP_PUSH      = 5'd0;
  localparam logic [4:0] OP_ADD       = 5'd1;
  localparam logic [4:0] OP_SUB       = 5'd2;
  localparam logic [4:0] OP_MUL       = 5'd3;
  localparam logic [4:0] OP_DIV       = 5'd4;
  localparam logic [4:0] OP_DROP      = 5'd5;
  localparam logic [4:0] OP_DUP       = 5'd6;
  localparam logic [4:0] OP_SWAP      = 5'd7;
  localparam logic [4:0] OP_ROT       = 5'd8;
  localparam logic [4:0] OP_OVER      = 5'd9;
  localparam logic [4:0] OP_PICK      = 5'd10;
  localparam logic [4:0] OP_COUNT     = 5'd11;
  localparam logic [4:0] OP_AND       = 5'd12;
  localparam logic [4:0] OP_OR        = 5'd13;
  localparam logic [4:0] OP_NOT       = 5'd14;
  localparam logic [4:0] OP_XOR       = 5'd15;
  localparam logic [4:0] OP_EQ        = 5'd16;
  localparam logic [4:0] OP_LT        = 5'd17;
  localparam logic [4:0] OP_GT        = 5'd18;
  localparam logic [4:0] OP_PRINT     = 5'd19;
  localparam logic [4:0] OP_EMIT      = 5'd20;
  localparam logic [4:0] OP_READCHAR  = 5'd21;
  localparam logic [4:0] OP_SKIPTRUE  = 5'd22;
  localparam logic [4:0] OP_SKIPFALSE = 5'd23;
  localparam logic [4:0] OP_STORE     = 5'd24;
  localparam logic [4:0] OP_LOAD      = 5'd25;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_INDEX = 3'd3;
  localparam logic [2:0] ST_ABORT = 3'd4;
  localparam logic [2:0] ST_DIVZ  = 3'd5;

  // print kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;

  // character codes
  localparam logic [7:0] CHAR_ETX    = 8'd3;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_A_LOW  = 8'd97;
  localparam logic [7:0] CHAR_Z_LOW  = 8'd122;

  // stack read address select
  typedef enum logic [1:0] {
    RD_TOP   = 2'd0,
    RD_SEC   = 2'd1,
    RD_THIRD = 2'd2
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    rd_sel_t    rd_sel;
    logic       cap_top;
    logic       cap_sec;
    logic       cap_third;
    logic       exec;
    logic [2:0] wr_sel;
    logic       load_out;
  } bsme_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_go;
    logic div_done;
  } bsme_stat_t;

endpackage

>>> src/bsme_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing; field widths follow the block's item layout.
interface bsme_in_if;
  logic              valid;
  logic              ready;
  logic [4:0]        operation;
  logic signed [7:0] literal;

  modport source (output valid, output operation, output literal, input ready);
  modport sink   (input valid, input operation, input literal, output ready);
endinterface

interface bsme_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [1:0]        out_kind;
  logic signed [7:0] out_value;
  logic              skip_next;
  logic [8:0]        stack_depth;

  modport source (output valid, output status, output out_kind, output out_value,
                  output skip_next, output stack_depth, input ready);
  modport sink   (input valid, input status, input out_kind, input out_value,
                  input skip_next, input stack_depth, output ready);
endinterface

>>> src/bsme_ctrl.sv
// Sequencing state machine: operand reads, execute, divide wait, write-back, result.
// Depends on bsme_pkg for the command and status structs.
module bsme_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bsme_pkg::bsme_stat_t stat,
  output bsme_pkg::bsme_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD1  = 10'b0000000010,
    S_RD2  = 10'b0000000100,
    S_RD3  = 10'b0000001000,
    S_EXEC = 10'b0000010000,
    S_DIVW = 10'b0000100000,
    S_WR0  = 10'b0001000000,
    S_WR1  = 10'b0010000000,
    S_WR2  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = bsme_pkg::RD_TOP;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.cap_top = 1'b1;
        cmd.rd_sel  = bsme_pkg::RD_SEC;
        state_nxt   = S_RD2;
      end
      S_RD2: begin
        cmd.cap_sec = 1'b1;
        cmd.rd_sel  = bsme_pkg::RD_THIRD;
        state_nxt   = S_RD3;
      end
      S_RD3: begin
        cmd.cap_third = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.div_go ? S_DIVW : S_WR0;
      end
      S_DIVW: begin
        if (stat.div_done) state_nxt = S_WR0;
      end
      S_WR0: begin
        cmd.wr_sel = 3'b001;
        state_nxt  = S_WR1;
      end
      S_WR1: begin
        cmd.wr_sel = 3'b010;
        state_nxt  = S_WR2;
      end
      S_WR2: begin
        cmd.wr_sel = 3'b100;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/bsme_dp.sv
// Datapath: stack memory, variable store, operand registers, execute logic,
// serial divider, configuration registers and the result register. Uses bsme_pkg.
module bsme_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [4:0]                          in_operation,
  input  logic [7:0]                          in_literal,
  input  logic                                cfg_we,
  input  logic [bsme_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bsme_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  bsme_pkg::bsme_cmd_t                 cmd,
  output bsme_pkg::bsme_stat_t                stat,
  output logic [2:0]                          res_status,
  output logic [1:0]                          res_kind,
  output logic [7:0]                          res_value,
  output logic                                res_skip,
  output logic [bsme_pkg::DEPTH_OUT_W-1:0]    res_depth
);

  localparam int AW = bsme_pkg::ADDR_W;
  localparam int SW = bsme_pkg::SP_W;
  localparam int VW = bsme_pkg::VAR_AW;

  // stack pointer, item and operands
  logic [SW-1:0] sp_r;
  logic [4:0]    op_r;
  logic [7:0]    lit_r;
  logic [7:0]    t0_r, t1_r, t2_r;
  logic [7:0]    true_r, false_r;

  // stack memory
  logic [7:0]    stk_mem [bsme_pkg::STACK_DEPTH];
  logic [7:0]    stk_rd_r;
  logic [AW-1:0] stk_raddr;
  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  logic [7:0]    stk_wdata;

  // variable store with per-entry valid bits
  logic [7:0]               var_mem [bsme_pkg::VAR_DEPTH];
  logic [bsme_pkg::VAR_DEPTH-1:0] var_vld_r;
  logic [7:0]               var_rd_r;
  logic                     var_hit_r;
  logic [VW-1:0]            var_addr;
  logic [7:0]               var_data;
  logic                     key_letter, key_neg;

  // execute plan registers
  logic [2:0]    res_st_r, res_st_x;
  logic [1:0]    res_kind_r, res_kind_x;
  logic [7:0]    res_val_r, res_val_x;
  logic          res_skip_r, res_skip_x;
  logic [SW-1:0] sp_new_r, sp_new_x;
  logic [2:0]    w_en_r, w_en_x;
  logic [AW-1:0] w_addr_r [3];
  logic [AW-1:0] w_addr_x [3];
  logic [7:0]    w_data_r [3];
  logic [7:0]    w_data_x [3];
  logic          var_we_r, var_we_x;
  logic [7:0]    var_wd_r;
  logic          div_go_x;

  // divider
  logic       div_busy_r;
  logic [2:0] div_cnt_r;
  logic [7:0] div_rem_r, div_quo_r, div_dv_r;
  logic       div_neg_r;
  logic [8:0] div_sh;
  logic       div_ge;
  logic [7:0] div_quo_nxt;

  // result register
  logic [2:0]                       out_st_r;
  logic [1:0]                       out_kind_r;
  logic [7:0]                       out_val_r;
  logic                             out_skip_r;
  logic [bsme_pkg::DEPTH_OUT_W-1:0] out_depth_r;

  // common addresses below the pointer
  logic [AW-1:0] a_n, a_1, a_2, a_3, a_pick;
  logic          ge1, ge2, ge3, full;
  logic [15:0]   prod;
  logic          cmp_true;

  assign a_n    = AW'(sp_r);
  assign a_1    = a_n - AW'(1);
  assign a_2    = a_n - AW'(2);
  assign a_3    = a_n - AW'(3);
  assign a_pick = a_1 - AW'(t0_r[6:0]);
  assign ge1    = (sp_r != '0);
  assign ge2    = (sp_r >= SW'(2));
  assign ge3    = (sp_r >= SW'(3));
  assign full   = (sp_r == SW'(bsme_pkg::STACK_DEPTH));

  // stack read address
  always_comb begin
    case (cmd.rd_sel)
      bsme_pkg::RD_TOP:   stk_raddr = a_1;
      bsme_pkg::RD_SEC:   stk_raddr = a_2;
      bsme_pkg::RD_THIRD: stk_raddr = (op_r == bsme_pkg::OP_ROT) ? a_3 : a_pick;
      default:            stk_raddr = a_1;
    endcase
  end

  // stack write port, one slot per write cycle
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = w_addr_r[0];
    stk_wdata = w_data_r[0];
    case (cmd.wr_sel)
      3'b001: begin
        stk_we = w_en_r[0]; stk_waddr = w_addr_r[0]; stk_wdata = w_data_r[0];
      end
      3'b010: begin
        stk_we = w_en_r[1]; stk_waddr = w_addr_r[1]; stk_wdata = w_data_r[1];
      end
      3'b100: begin
        stk_we = w_en_r[2]; stk_waddr = w_addr_r[2]; stk_wdata = w_data_r[2];
      end
      default: stk_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd_r <= stk_mem[stk_raddr];
  end

  // key decode for store and load
  assign key_letter = (t0_r >= bsme_pkg::CHAR_A_LOW) && (t0_r <= bsme_pkg::CHAR_Z_LOW);
  assign key_neg    = t0_r[7];
  assign var_addr   = key_neg ? VW'(t0_r[6:0])
                              : VW'(bsme_pkg::ARRAY_SIZE) + VW'(t0_r - bsme_pkg::CHAR_A_LOW);
  assign var_data   = var_hit_r ? var_rd_r : 8'd0;

  // variable store, never-written entries read as zero
  always_ff @(posedge clk) begin
    if (var_we_r && cmd.wr_sel[0]) var_mem[var_addr] <= var_wd_r;
    var_rd_r <= var_mem[var_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_vld_r <= '0;
      var_hit_r <= 1'b0;
    end else begin
      if (var_we_r && cmd.wr_sel[0]) var_vld_r[var_addr] <= 1'b1;
      var_hit_r <= var_vld_r[var_addr];
    end
  end

  assign prod = t1_r * t0_r;
  always_comb begin
    case (op_r)
      bsme_pkg::OP_EQ: cmp_true = ($signed(t1_r) == $signed(t0_r));
      bsme_pkg::OP_LT: cmp_true = ($signed(t1_r) <  $signed(t0_r));
      default:         cmp_true = ($signed(t1_r) >  $signed(t0_r));
    endcase
  end

  // execute: status, new pointer and write plan
  always_comb begin
    res_st_x   = bsme_pkg::ST_OK;
    res_kind_x = bsme_pkg::KIND_NONE;
    res_val_x  = 8'd0;
    res_skip_x = 1'b0;
    sp_new_x   = sp_r;
    w_en_x     = 3'b000;
    var_we_x   = 1'b0;
    div_go_x   = 1'b0;
    for (int k = 0; k < 3; k++) begin
      w_addr_x[k] = a_1;
      w_data_x[k] = 8'd0;
    end
    case (op_r)
      bsme_pkg::OP_PUSH, bsme_pkg::OP_COUNT, bsme_pkg::OP_READCHAR: begin
        if (full) res_st_x = bsme_pkg::ST_OVER;
        else if (op_r == bsme_pkg::OP_READCHAR && lit_r == bsme_pkg::CHAR_ETX)
          res_st_x = bsme_pkg::ST_ABORT;
        else begin
          w_en_x[0]   = 1'b1;
          w_addr_x[0] = a_n;
          if (op_r == bsme_pkg::OP_PUSH) w_data_x[0] = lit_r;
          else if (op_r == bsme_pkg::OP_COUNT) w_data_x[0] = 8'(sp_r);
          else w_data_x[0] = (lit_r == bsme_pkg::CHAR_CR) ? bsme_pkg::CHAR_LF : lit_r;
          sp_new_x = sp_r + SW'(1);
        end
      end
      bsme_pkg::OP_ADD, bsme_pkg::OP_SUB, bsme_pkg::OP_MUL, bsme_pkg::OP_DIV,
      bsme_pkg::OP_AND, bsme_pkg::OP_OR, bsme_pkg::OP_XOR: begin
        if (!ge2) res_st_x = bsme_pkg::ST_UNDER;
        else if (op_r == bsme_pkg::OP_DIV && t0_r == 8'd0) res_st_x = bsme_pkg::ST_DIVZ;
        else begin
          w_en_x[0]   = 1'b1;
          w_addr_x[0] = a_2;
          case (op_r)
            bsme_pkg::OP_ADD: w_data_x[0] = t1_r + t0_r;
            bsme_pkg::OP_SUB: w_data_x[0] = t1_r - t0_r;
            bsme_pkg::OP_MUL: w_data_x[0] = prod[7:0];
            bsme_pkg::OP_AND: w_data_x[0] = t1_r & t0_r;
            bsme_pkg::OP_OR:  w_data_x[0] = t1_r | t0_r;
            bsme_pkg::OP_XOR: w_data_x[0] = t1_r ^ t0_r;
            default:          div_go_x    = 1'b1;
          endcase
          sp_new_x = sp_r - SW'(1);
        end
      end
      bsme_pkg::OP_DROP: begin
        if (!ge1) res_st_x = bsme_pkg::ST_UNDER;
        else sp_new_x = sp_r - SW'(1);
      end
      bsme_pkg::OP_DUP, bsme_pkg::OP_OVER: begin
        if (op_r == bsme_pkg::OP_DUP ? !ge1 : !ge2) res_st_x = bsme_pkg::ST_UNDER;
        else if (full) res_st_x = bsme_pkg::ST_OVER;
        else begin
          w_en_x[0]   = 1'b1;
          w_addr_x[0] = a_n;
          w_data_x[0] = (op_r == bsme_pkg::OP_DUP) ? t0_r : t1_r;
          sp_new_x    = sp_r + SW'(1);
        end
      end
      bsme_pkg::OP_SWAP: begin
        if (!ge2) res_st_x = bsme_pkg::ST_UNDER;
        else begin
          w_en_x      = 3'b011;
          w_addr_x[0] = a_1;
          w_data_x[0] = t1_r;
          w_addr_x[1] = a_2;
          w_data_x[1] = t0_r;
        end
      end
      bsme_pkg::OP_ROT: begin
        if (!ge3) res_st_x = bsme_pkg::ST_UNDER;
        else begin
          w_en_x      = 3'b111;
          w_addr_x[0] = a_3;
          w_data_x[0] = t1_r;
          w_addr_x[1] = a_2;
          w_data_x[1] = t0_r;
          w_addr_x[2] = a_1;
          w_data_x[2] = t2_r;
        end
      end
      bsme_pkg::OP_PICK: begin
        if (!ge2) res_st_x = bsme_pkg::ST_UNDER;
        else if (full) res_st_x = bsme_pkg::ST_OVER;
        else if (!t0_r[7] && (9'(t0_r[6:0]) >= 9'(sp_r))) res_st_x = bsme_pkg::ST_UNDER;
        else if (t0_r[7]) res_st_x = bsme_pkg::ST_OVER;
        else begin
          w_en_x[0]   = 1'b1;
          w_addr_x[0] = a_n;
          w_data_x[0] = t2_r;
          sp_new_x    = sp_r + SW'(1);
        end
      end
      bsme_pkg::OP_NOT: begin
        if (!ge1) res_st_x = bsme_pkg::ST_UNDER;
        else begin
          w_en_x[0]   = 1'b1;
          w_data_x[0] = ~t0_r;
        end
      end
      bsme_pkg::OP_EQ, bsme_pkg::OP_LT, bsme_pkg::OP_GT: begin
        if (!ge2) res_st_x = bsme_pkg::ST_UNDER;
        else begin
          w_en_x[0]   = 1'b1;
          w_data_x[0] = cmp_true ? true_r : false_r;
        end
      end
      bsme_pkg::OP_PRINT, bsme_pkg::OP_EMIT: begin
        if (!ge1) res_st_x = bsme_pkg::ST_UNDER;
        else begin
          res_val_x = t0_r;
          if (op_r == bsme_pkg::OP_PRINT) res_kind_x = bsme_pkg::KIND_INT;
          else begin
            res_kind_x = bsme_pkg::KIND_CHAR;
            sp_new_x   = sp_r - SW'(1);
          end
        end
      end
      bsme_pkg::OP_SKIPTRUE, bsme_pkg::OP_SKIPFALSE: begin
        if (!ge1) res_st_x = bsme_pkg::ST_UNDER;
        else begin
          res_skip_x = ((t0_r != 8'd0) == (op_r == bsme_pkg::OP_SKIPTRUE));
          sp_new_x   = sp_r - SW'(1);
        end
      end
      bsme_pkg::OP_STORE, bsme_pkg::OP_LOAD: begin
        if (!ge1) res_st_x = bsme_pkg::ST_UNDER;
        else if (!key_letter && !key_neg) res_st_x = bsme_pkg::ST_INDEX;
        else if (op_r == bsme_pkg::OP_STORE) begin
          if (!ge2) res_st_x = bsme_pkg::ST_UNDER;
          else begin
            var_we_x = 1'b1;
            sp_new_x = sp_r - SW'(1);
          end
        end else begin
          w_en_x[0]   = 1'b1;
          w_data_x[0] = var_data;
        end
      end
      default: res_st_x = bsme_pkg::ST_OK;
    endcase
    // an error leaves the state alone
    if (res_st_x != bsme_pkg::ST_OK) begin
      res_kind_x = bsme_pkg::KIND_NONE;
      res_val_x  = 8'd0;
      res_skip_x = 1'b0;
      sp_new_x   = sp_r;
      w_en_x     = 3'b000;
      var_we_x   = 1'b0;
      div_go_x   = 1'b0;
    end
  end

  assign stat.div_go   = div_go_x;
  assign stat.div_done = div_busy_r && (div_cnt_r == 3'd7);

  // one restoring divide step per cycle on magnitudes
  assign div_sh      = {div_rem_r, div_quo_r[7]};
  assign div_ge      = (div_sh >= {1'b0, div_dv_r});
  assign div_quo_nxt = {div_quo_r[6:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.exec && div_go_x) begin
      div_busy_r <= 1'b1;
    end else if (stat.div_done) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && div_go_x) begin
      div_cnt_r <= 3'd0;
      div_rem_r <= 8'd0;
      div_quo_r <= t1_r[7] ? 8'(-t1_r) : t1_r;
      div_dv_r  <= t0_r[7] ? 8'(-t0_r) : t0_r;
      div_neg_r <= t1_r[7] ^ t0_r[7];
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + 3'd1;
      div_rem_r <= div_ge ? 8'(div_sh - {1'b0, div_dv_r}) : div_sh[7:0];
      div_quo_r <= div_quo_nxt;
    end
  end

  // item capture, operand capture and execute plan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      lit_r <= in_literal;
    end
    if (cmd.cap_top)   t0_r <= stk_rd_r;
    if (cmd.cap_sec)   t1_r <= stk_rd_r;
    if (cmd.cap_third) t2_r <= stk_rd_r;
    if (cmd.exec) begin
      res_st_r   <= res_st_x;
      res_kind_r <= res_kind_x;
      res_val_r  <= res_val_x;
      res_skip_r <= res_skip_x;
      sp_new_r   <= sp_new_x;
      var_wd_r   <= t1_r;
      for (int k = 0; k < 3; k++) begin
        w_addr_r[k] <= w_addr_x[k];
        w_data_r[k] <= w_data_x[k];
      end
    end else if (stat.div_done) begin
      w_data_r[0] <= div_neg_r ? 8'(-div_quo_nxt) : div_quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_en_r   <= 3'b000;
      var_we_r <= 1'b0;
    end else if (cmd.exec) begin
      w_en_r   <= w_en_x;
      var_we_r <= var_we_x;
    end
  end

  // stack pointer commits with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.load_out) begin
      sp_r <= sp_new_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      true_r  <= 8'd1;
      false_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bsme_pkg::CFG_TRUE_VALUE:  true_r  <= cfg_wdata;
        bsme_pkg::CFG_FALSE_VALUE: false_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_st_r    <= res_st_r;
      out_kind_r  <= res_kind_r;
      out_val_r   <= res_val_r;
      out_skip_r  <= res_skip_r;
      out_depth_r <= bsme_pkg::DEPTH_OUT_W'(sp_new_r);
    end
  end

  assign res_status = out_st_r;
  assign res_kind   = out_kind_r;
  assign res_value  = out_val_r;
  assign res_skip   = out_skip_r;
  assign res_depth  = out_depth_r;

endmodule

>>> src/byte_stack_machine_executor_core.sv
// Top level of the byte stack machine executor: controller plus datapath.
// Depends on bsme_pkg, bsme_if (channel interfaces), bsme_ctrl and bsme_dp.
//
// Usage:
//   in_if carries one decoded primitive per item (operation, literal). out_if
//   returns exactly one result item per input item: status, print kind and
//   value, skip flag and the stack depth after the step.
//   cfg_we/cfg_idx/cfg_wdata write true_value (index 0) or false_value
//   (index 1); write them only while no item is in flight.
// Sequence:
//   An item is taken in the idle state; the controller then does three
//   operand reads, execute, three write-back steps and a done step that loads
//   the result and returns to idle for the next item. A divide adds a wait
//   state (one quotient bit per cycle). The stack memory has one read and one
//   write port: operand reads and write-backs go through them one per cycle.
// Reset and stall:
//   Synchronous active-low reset empties the stack, zeros the variables and
//   the data array, and sets true_value to 1, false_value to 0.
//   A finished result sits in the output register; the next item is still
//   accepted and worked on, and holds in its last step until the register
//   frees.
module byte_stack_machine_executor_core (
  input  logic                                clk,
  input  logic                                rst_n,
  bsme_in_if.sink                             in_if,
  bsme_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [bsme_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bsme_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  bsme_pkg::bsme_cmd_t  cmd;
  bsme_pkg::bsme_stat_t stat;
  logic [7:0]           res_value;

  // sequencing
  bsme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // stack, stores, execute and result register
  bsme_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_if.operation),
    .in_literal   (in_if.literal),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .res_status   (out_if.status),
    .res_kind     (out_if.out_kind),
    .res_value    (res_value),
    .res_skip     (out_if.skip_next),
    .res_depth    (out_if.stack_depth)
  );

  assign out_if.out_value = $signed(res_value);

endmodule

>>> bench/tb_top.sv
// Testbench for byte_stack_machine_executor_core: directed and random primitives,
// each result checked field by field against an in-bench model of the stack machine.
// Depends on bsme_pkg, the bsme_if channel interfaces and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsme_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS   = 130;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [7:0] CHAR_A_UP = 8'h41;

  // one result item as seen on the output channel
  typedef struct packed {
    logic [2:0] status;
    logic [1:0] kind;
    logic [7:0] value;
    logic       skip;
    logic [8:0] depth;
  } step_result_t;

  // model of the machine state plus the queue of results still to come
  class stack_machine_tracker;
    logic [7:0]   stack_mem [STACK_DEPTH];
    int           depth;
    logic [7:0]   letters [VARIABLE_COUNT];
    logic [7:0]   cells [ARRAY_SIZE];
    logic [7:0]   true_val;
    logic [7:0]   false_val;
    step_result_t expected_results [$];
    int           errors;

    function new();
      depth     = 0;
      true_val  = 8'd1;
      false_val = 8'd0;
      errors    = 0;
      foreach (stack_mem[i]) stack_mem[i] = '0;
      foreach (letters[i]) letters[i] = '0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      if (idx == CFG_TRUE_VALUE) true_val = data;
      else false_val = data;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // run one primitive on the model and queue its result
    function void take_item(logic [4:0] op, logic [7:0] lit);
      step_result_t res;
      int           n;
      int           i;
      int           sel;
      logic [7:0]   a;
      logic [7:0]   b;
      logic [7:0]   r;
      logic [7:0]   v;
      logic [7:0]   key;
      logic [2:0]   st;
      logic [1:0]   kind;
      logic         skip;
      logic         holds;
      n    = depth;
      st   = ST_OK;
      kind = KIND_NONE;
      v    = '0;
      r    = '0;
      skip = 1'b0;
      case (op)
        OP_PUSH, OP_COUNT, OP_READCHAR: begin
          if (n >= STACK_DEPTH) st = ST_OVER;
          else if (op == OP_READCHAR && lit == CHAR_ETX) st = ST_ABORT;
          else begin
            if (op == OP_PUSH) stack_mem[n] = lit;
            else if (op == OP_COUNT) stack_mem[n] = 8'(n);
            else stack_mem[n] = (lit == CHAR_CR) ? CHAR_LF : lit;
            n++;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR: begin
          if (n < 2) st = ST_UNDER;
          else begin
            a = stack_mem[n-2];
            b = stack_mem[n-1];
            case (op)
              OP_ADD: r = a + b;
              OP_SUB: r = a - b;
              OP_MUL: r = a * b;
              OP_DIV: begin
                // truncating signed divide, most negative over minus one wraps
                if (b == 8'd0) st = ST_DIVZ;
                else r = 8'(int'($signed(a)) / int'($signed(b)));
              end
              OP_AND: r = a & b;
              OP_OR:  r = a | b;
              default: r = a ^ b;
            endcase
            if (st == ST_OK) begin
              stack_mem[n-2] = r;
              n--;
            end
          end
        end
        OP_DROP: begin
          if (n < 1) st = ST_UNDER;
          else n--;
        end
        OP_DUP, OP_OVER: begin
          sel = (op == OP_DUP) ? 1 : 2;
          if (n < sel) st = ST_UNDER;
          else if (n >= STACK_DEPTH) st = ST_OVER;
          else begin
            stack_mem[n] = stack_mem[n-sel];
            n++;
          end
        end
        OP_SWAP: begin
          if (n < 2) st = ST_UNDER;
          else begin
            a              = stack_mem[n-1];
            stack_mem[n-1] = stack_mem[n-2];
            stack_mem[n-2] = a;
          end
        end
        OP_ROT: begin
          if (n < 3) st = ST_UNDER;
          else begin
            a              = stack_mem[n-3];
            stack_mem[n-3] = stack_mem[n-2];
            stack_mem[n-2] = stack_mem[n-1];
            stack_mem[n-1] = a;
          end
        end
        OP_PICK: begin
          // index checks come after the underflow and full-stack checks
          if (n < 2) st = ST_UNDER;
          else if (n >= STACK_DEPTH) st = ST_OVER;
          else begin
            i = int'($signed(stack_mem[n-1]));
            if (i >= n) st = ST_UNDER;
            else if (i < 0) st = ST_OVER;
            else begin
              stack_mem[n] = stack_mem[n-i-1];
              n++;
            end
          end
        end
        OP_NOT: begin
          if (n < 1) st = ST_UNDER;
          else stack_mem[n-1] = ~stack_mem[n-1];
        end
        OP_EQ, OP_LT, OP_GT: begin
          // compare replaces the top only, depth unchanged
          if (n < 2) st = ST_UNDER;
          else begin
            a = stack_mem[n-2];
            b = stack_mem[n-1];
            if (op == OP_EQ) holds = (a == b);
            else if (op == OP_LT) holds = ($signed(a) < $signed(b));
            else holds = ($signed(a) > $signed(b));
            stack_mem[n-1] = holds ? true_val : false_val;
          end
        end
        OP_PRINT, OP_EMIT: begin
          if (n < 1) st = ST_UNDER;
          else begin
            v    = stack_mem[n-1];
            kind = (op == OP_PRINT) ? KIND_INT : KIND_CHAR;
            if (op == OP_EMIT) n--;
          end
        end
        OP_SKIPTRUE, OP_SKIPFALSE: begin
          if (n < 1) st = ST_UNDER;
          else begin
            skip = ((stack_mem[n-1] != 8'd0) == (op == OP_SKIPTRUE));
            n--;
          end
        end
        OP_STORE, OP_LOAD: begin
          // lowercase letter keys hit variables, negative keys hit the array
          if (n < 1) st = ST_UNDER;
          else begin
            key = stack_mem[n-1];
            if (!(key >= CHAR_A_LOW && key <= CHAR_Z_LOW) && !key[7]) st = ST_INDEX;
            else if (op == OP_STORE) begin
              if (n < 2) st = ST_UNDER;
              else begin
                if (key[7]) cells[key[6:0]] = stack_mem[n-2];
                else letters[key - CHAR_A_LOW] = stack_mem[n-2];
                n--;
              end
            end else begin
              stack_mem[n-1] = key[7] ? cells[key[6:0]] : letters[key - CHAR_A_LOW];
            end
          end
        end
        default: ;
      endcase
      if (st == ST_OK) depth = n;
      else begin
        kind = KIND_NONE;
        v    = '0;
        skip = 1'b0;
      end
      res.status = st;
      res.kind   = kind;
      res.value  = v;
      res.skip   = skip;
      res.depth  = 9'(depth);
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(step_result_t got);
      step_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with no item pending, status %0d depth %0d",
                 $time, got.status, got.depth);
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("out_kind", want.kind, got.kind);
      compare_field("out_value", $signed(want.value), $signed(got.value));
      compare_field("skip_next", want.skip, got.skip);
      compare_field("stack_depth", want.depth, got.depth);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bsme_in_if  in_ch ();
  bsme_out_if out_ch ();

  byte_stack_machine_executor_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  stack_machine_tracker tracker = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int items_sent    = 0;
  int cycle_count   = 0;

  // clock
  initial clk = 1'b0;
  always #(CLK_PERIOD/2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result(step_result_t'({out_ch.status, out_ch.out_kind,
                                           out_ch.out_value, out_ch.skip_next,
                                           out_ch.stack_depth}));
  end

  // drive one item, with random sender gaps, and hand it to the model on accept
  task automatic send_item(logic [4:0] op, logic [7:0] lit);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.literal   = lit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_item(op, lit);
    if (op <= OP_LOAD) items_sent++;
  endtask

  // stop sending and let every pending result come back
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.write_reg(idx, data);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(11))
      0: return 8'h80;
      1: return 8'h7f;
      2: return 8'h00;
      3: return 8'hff;
      4: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // store/load keys: letters, a few array slots, any negative, uppercase, other
  function automatic logic [7:0] rand_key();
    case ($urandom_range(5))
      0, 1: return CHAR_A_LOW + 8'($urandom_range(25));
      2: return 8'h80 | 8'($urandom_range(7));
      3: return 8'h80 | 8'($urandom_range(127));
      4: return CHAR_A_UP + 8'($urandom_range(25));
      default: return 8'($urandom_range(127));
    endcase
  endfunction

  function automatic logic [4:0] binary_op();
    case ($urandom_range(9))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      3: return OP_DIV;
      4: return OP_AND;
      5: return OP_OR;
      6: return OP_XOR;
      7: return OP_EQ;
      8: return OP_LT;
      default: return OP_GT;
    endcase
  endfunction

  function automatic logic [4:0] stack_op();
    case ($urandom_range(8))
      0: return OP_DROP;
      1: return OP_DUP;
      2: return OP_SWAP;
      3: return OP_ROT;
      4: return OP_OVER;
      5: return OP_NOT;
      6: return OP_COUNT;
      7: return OP_PRINT;
      default: return OP_EMIT;
    endcase
  endfunction

  function automatic logic [4:0] shrink_op();
    case ($urandom_range(4))
      0: return OP_EMIT;
      1: return OP_DROP;
      2: return OP_SKIPFALSE;
      3: return OP_SKIPTRUE;
      default: return binary_op();
    endcase
  endfunction

  // hand-picked opening: extremes, special cases and a spread of primitive kinds
  task automatic run_directed();
    send_item(OP_DROP, 8'h00);        // underflow on empty stack
    send_item(OP_PUSH, 8'h80);
    send_item(OP_PUSH, 8'hff);
    send_item(OP_DIV, 8'h00);         // most negative over minus one wraps
    send_item(OP_PUSH, 8'h00);
    send_item(OP_DIV, 8'h00);         // divide by zero
    send_item(OP_READCHAR, CHAR_ETX); // abort
    send_item(OP_READCHAR, CHAR_CR);  // carriage return becomes line feed
    send_item(OP_EMIT, 8'h00);
    send_item(OP_PUSH, CHAR_Z_LOW);
    send_item(OP_STORE, 8'h00);
    send_item(OP_PUSH, 8'h80);
    send_item(OP_STORE, 8'h00);
    send_item(OP_PUSH, CHAR_A_UP);    // uppercase key is a bad index
    send_item(OP_LOAD, 8'h7f);
    send_item(OP_PUSH, 8'd2);
    send_item(OP_PICK, 8'h00);
    send_item(OP_COUNT, 8'h00);
    send_item(OP_PRINT, 8'h00);
    send_item(OP_LT, 8'h00);
    send_item(OP_GT, 8'h00);
    send_item(OP_EQ, 8'h00);
    send_item(OP_SKIPTRUE, 8'h00);
    send_item(OP_SKIPFALSE, 8'h00);
    send_item(5'd31, 8'hff);          // unused code is ignored
  endtask

  // one random sequence, mostly well formed with random operands
  task automatic random_sequence();
    int         d;
    int         choice;
    int         idx;
    logic [7:0] key;
    logic [7:0] ch;
    d      = tracker.depth;
    choice = $urandom_range(99);
    if ($urandom_range(63) < d) begin
      // keep the stack shallow most of the time
      send_item(shrink_op(), rand_byte());
    end else if (choice < 25) begin
      send_item(OP_PUSH, rand_byte());
      send_item(OP_PUSH, rand_byte());
      send_item(binary_op(), rand_byte());
    end else if (choice < 40) begin
      // store, then load back the same key or another one
      key = rand_key();
      send_item(OP_PUSH, rand_byte());
      send_item(OP_PUSH, key);
      send_item(OP_STORE, rand_byte());
      send_item(OP_PUSH, ($urandom_range(3) == 0) ? rand_key() : key);
      send_item(OP_LOAD, rand_byte());
      send_item($urandom_range(1) ? OP_PRINT : OP_EMIT, rand_byte());
    end else if (choice < 50) begin
      // pick inside range, past the depth, or negative
      case ($urandom_range(2))
        0: idx = $urandom_range(d);
        1: idx = d + 1 + $urandom_range(2);
        default: idx = -1 - $urandom_range(127);
      endcase
      if (idx > 127) idx = 127;
      send_item(OP_PUSH, 8'(idx));
      send_item(OP_PICK, rand_byte());
    end else if (choice < 58) begin
      case ($urandom_range(2))
        0: ch = CHAR_ETX;
        1: ch = CHAR_CR;
        default: ch = rand_byte();
      endcase
      send_item(OP_READCHAR, ch);
      send_item(OP_EMIT, rand_byte());
    end else if (choice < 68) begin
      send_item(OP_PUSH, $urandom_range(1) ? 8'h00 : rand_byte());
      send_item($urandom_range(1) ? OP_SKIPTRUE : OP_SKIPFALSE, rand_byte());
    end else if (choice < 90) begin
      send_item(stack_op(), rand_byte());
    end else begin
      send_item(5'($urandom_range(31)), rand_byte());
    end
  endtask

  // fill the stack to the top, hit every push at full, then unwind
  task automatic fill_and_unwind();
    int k;
    while (tracker.depth < STACK_DEPTH) begin
      k = $urandom_range(9);
      if (k == 0) send_item(OP_COUNT, rand_byte());
      else if (k == 1) send_item(OP_READCHAR, rand_byte());
      else send_item(OP_PUSH, rand_byte());
    end
    send_item(OP_PUSH, 8'h7f);
    send_item(OP_COUNT, 8'h00);
    send_item(OP_READCHAR, CHAR_ETX);
    send_item(OP_DUP, 8'h00);
    send_item(OP_OVER, 8'h00);
    send_item(OP_PICK, 8'h00);
    send_item(OP_DROP, 8'h00);
    send_item(OP_DROP, 8'h00);
    send_item(OP_PUSH, 8'hfd);        // negative pick index
    send_item(OP_PICK, 8'h00);
    send_item(OP_DROP, 8'h00);
    send_item(OP_PUSH, 8'd127);       // deepest reachable pick
    send_item(OP_PICK, 8'h00);
    while (tracker.depth > 4) begin
      case ($urandom_range(7))
        0: send_item(OP_ADD, 8'h00);
        1: send_item(OP_PRINT, 8'h00);
        2: send_item(OP_SKIPFALSE, 8'h00);
        3: send_item(OP_ROT, 8'h00);
        4: send_item(OP_XOR, 8'h00);
        5: send_item(OP_DROP, 8'h00);
        default: send_item(OP_EMIT, 8'h00);
      endcase
    end
  endtask

  // comparison results per phase, extremes included
  task automatic apply_phase_config(int p);
    logic [7:0] tv;
    logic [7:0] fv;
    case (p)
      0: begin tv = 8'h01; fv = 8'h00; end
      1: begin tv = 8'h80; fv = 8'h7f; end
      2: begin tv = 8'h7f; fv = 8'h80; end
      3: begin tv = 8'h00; fv = 8'h00; end
      4: begin tv = 8'hff; fv = 8'h01; end
      6: begin tv = 8'h7f; fv = 8'h7f; end
      7: begin tv = 8'h80; fv = 8'h80; end
      default: begin tv = 8'($urandom); fv = 8'($urandom); end
    endcase
    wait_idle();
    write_reg(CFG_TRUE_VALUE, tv);
    write_reg(CFG_FALSE_VALUE, fv);
  endtask

  // main sequence
  initial begin
    int start;
    bit paused;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_PUSH;
    in_ch.literal   = '0;
    paused          = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    for (int p = 0; p < 8; p++) begin
      apply_phase_config(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        random_sequence();
        // sender holds off until the block has drained
        if (p == 2 && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      if (p == 3) fill_and_unwind();
    end

    wait_idle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
